@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/mcb_pkg.sv @@
// Package for the Morton code unit: widths, defaults and register indexes.
// Used by the top level, mcb_lane and mcb_merge; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mcb_pkg;
  localparam int unsigned COORD_W          = 32;
  localparam int unsigned NUM_AXES         = 3;
  localparam int unsigned BITS_PER_AXIS_DEF = 10;
  localparam int unsigned CFG_IDX_W        = 3;
  // Differences and sums of two Q16.16 values, and twice a difference.
  localparam int unsigned SUM_W            = COORD_W + 3;
  localparam int unsigned DEN_W            = COORD_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCENE_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCENE_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCENE_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCENE_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCENE_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCENE_MAX_Z = 3'd5;

  localparam logic [COORD_W-1:0] SCENE_MIN_RST = 32'h0000_0000;
  localparam logic [COORD_W-1:0] SCENE_MAX_RST = 32'h0001_0000;
endpackage
`default_nettype wire

@@ rtl/morton_code_from_box_centroid_unit.sv @@
// Top level of the Morton code unit: stream ports, scene registers, three
// axis lanes and the merging output stage. Depends on mcb_pkg, mcb_lane, mcb_merge.
`timescale 1ns / 1ps
`default_nettype none
// Takes one box per cycle while the output is not stalled and returns one Morton
// code per box, in order. One stage forms the centroid offset and scene extent,
// one restoring division stage per quotient bit follows in each axis lane, and a
// last stage interleaves the three axes. Each stage holds its beat only while the
// stage after it is full and stalled, so bubbles are squeezed out and input beats
// flow while a result waits, until all stages are full. Scene registers are written
// via the cfg port; the user must do so only while no beat is in flight, unenforced.
module morton_code_from_box_centroid_unit #(
  parameter int unsigned BITS_PER_AXIS = mcb_pkg::BITS_PER_AXIS_DEF,
  localparam int unsigned OUT_TDATA_W  = ((3 * BITS_PER_AXIS + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mcb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mcb_pkg::COORD_W-1:0]       cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  wire logic [6*mcb_pkg::COORD_W-1:0]     s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // morton_code, zero padding
  output logic [OUT_TDATA_W-1:0]                 m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import mcb_pkg::*;

  localparam int unsigned NS = BITS_PER_AXIS + 2;

  logic [COORD_W-1:0] smin_q [NUM_AXES];
  logic [COORD_W-1:0] smax_q [NUM_AXES];
  logic [NS-1:0]      vld_q;
  logic [NS:0]        en;
  logic               last_q [0:BITS_PER_AXIS];
  logic [BITS_PER_AXIS-1:0] q [NUM_AXES];
  logic [3*BITS_PER_AXIS-1:0] code;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        smin_q[a] <= SCENE_MIN_RST;
        smax_q[a] <= SCENE_MAX_RST;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCENE_MIN_X: smin_q[0] <= cfg_data_i;
        REG_SCENE_MIN_Y: smin_q[1] <= cfg_data_i;
        REG_SCENE_MIN_Z: smin_q[2] <= cfg_data_i;
        REG_SCENE_MAX_X: smax_q[0] <= cfg_data_i;
        REG_SCENE_MAX_Y: smax_q[1] <= cfg_data_i;
        REG_SCENE_MAX_Z: smax_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[NS] = m_axis_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) last_q[0] <= s_axis_tlast;
    for (int i = 1; i <= BITS_PER_AXIS; i++) begin
      if (en[i]) last_q[i] <= last_q[i-1];
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mcb_lane #(.BITS_PER_AXIS(BITS_PER_AXIS)) u_lane (
      .clk_i       (clk_i),
      .en_i        (en[BITS_PER_AXIS:0]),
      .box_min_i   (s_axis_tdata[a*COORD_W +: COORD_W]),
      .box_max_i   (s_axis_tdata[(a+NUM_AXES)*COORD_W +: COORD_W]),
      .scene_min_i (smin_q[a]),
      .scene_max_i (smax_q[a]),
      .q_o         (q[a])
    );
  end

  mcb_merge #(.BITS_PER_AXIS(BITS_PER_AXIS)) u_merge (
    .clk_i  (clk_i),
    .en_i   (en[NS-1]),
    .qx_i   (q[0]),
    .qy_i   (q[1]),
    .qz_i   (q[2]),
    .last_i (last_q[BITS_PER_AXIS]),
    .code_o (code),
    .last_o (m_axis_tlast)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = OUT_TDATA_W'(code);
endmodule
`default_nettype wire

@@ rtl/mcb_lane.sv @@
// One axis lane: centroid offset, scene extent, then one restoring division
// step per pipeline stage. Depends on mcb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcb_lane #(
  parameter int unsigned BITS_PER_AXIS = mcb_pkg::BITS_PER_AXIS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic [BITS_PER_AXIS:0]            en_i,
  input  wire logic [mcb_pkg::COORD_W-1:0]       box_min_i,
  input  wire logic [mcb_pkg::COORD_W-1:0]       box_max_i,
  input  wire logic [mcb_pkg::COORD_W-1:0]       scene_min_i,
  input  wire logic [mcb_pkg::COORD_W-1:0]       scene_max_i,
  output logic      [BITS_PER_AXIS-1:0]          q_o
);
  import mcb_pkg::*;

  localparam int unsigned B = BITS_PER_AXIS;

  logic signed [SUM_W-1:0] num, den_full;
  logic                    zero, sat;

  logic [DEN_W-1:0] rem_q  [0:B];
  logic [DEN_W-1:0] den_q  [0:B];
  logic [B-1:0]     qb_q   [0:B];
  logic             zero_q [0:B];
  logic             sat_q  [0:B];

  always_comb begin
    num = $signed({{3{box_min_i[COORD_W-1]}}, box_min_i})
        + $signed({{3{box_max_i[COORD_W-1]}}, box_max_i})
        - ($signed({{3{scene_min_i[COORD_W-1]}}, scene_min_i}) <<< 1);
    den_full = ($signed({{3{scene_max_i[COORD_W-1]}}, scene_max_i})
              - $signed({{3{scene_min_i[COORD_W-1]}}, scene_min_i})) <<< 1;
    zero = ($signed(scene_max_i) <= $signed(scene_min_i)) || (num <= 0);
    // A centroid at or past the scene maximum gives a quotient of 2^B or more.
    sat  = !zero && ($unsigned(num) >= {1'b0, den_full[DEN_W-1:0]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= num[DEN_W-1:0];
      den_q[0]  <= den_full[DEN_W-1:0];
      qb_q[0]   <= '0;
      zero_q[0] <= zero;
      sat_q[0]  <= sat;
    end
  end

  for (genvar k = 1; k <= B; k++) begin : g_step
    logic [DEN_W:0] r2;
    logic           ge;
    always_comb begin
      r2 = {rem_q[k-1], 1'b0};
      ge = r2 >= {1'b0, den_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= ge ? DEN_W'(r2 - {1'b0, den_q[k-1]}) : r2[DEN_W-1:0];
        den_q[k]  <= den_q[k-1];
        qb_q[k]   <= (qb_q[k-1] << 1) | B'(ge);
        zero_q[k] <= zero_q[k-1];
        sat_q[k]  <= sat_q[k-1];
      end
    end
  end

  assign q_o = zero_q[B] ? '0 : (sat_q[B] ? '1 : qb_q[B]);
endmodule
`default_nettype wire

@@ rtl/mcb_merge.sv @@
// Output stage: interleaves the three lane results into the Morton code and
// registers it with the last flag. Depends on mcb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcb_merge #(
  parameter int unsigned BITS_PER_AXIS = mcb_pkg::BITS_PER_AXIS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [BITS_PER_AXIS-1:0]     qx_i,
  input  wire logic [BITS_PER_AXIS-1:0]     qy_i,
  input  wire logic [BITS_PER_AXIS-1:0]     qz_i,
  input  wire logic                         last_i,
  output logic [3*BITS_PER_AXIS-1:0]        code_o,
  output logic                              last_o
);
  import mcb_pkg::*;

  logic [3*BITS_PER_AXIS-1:0] code_d, code_q;
  logic                       last_q;

  always_comb begin
    code_d = '0;
    for (int k = 0; k < BITS_PER_AXIS; k++) begin
      code_d[NUM_AXES*k+2] = qx_i[k];
      code_d[NUM_AXES*k+1] = qy_i[k];
      code_d[NUM_AXES*k]   = qz_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_q <= code_d;
      last_q <= last_i;
    end
  end

  assign code_o = code_q;
  assign last_o = last_q;
endmodule
`default_nettype wire

@@ rtl/mcb_checker.sv @@
// Port-level checker for the Morton code unit, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mcb_checker #(
  parameter int unsigned BITS_PER_AXIS = 10,
  parameter int unsigned OUT_TDATA_W   = 32
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);
  // With the output side empty or draining, the whole pipeline can move.
  `ASSERT_IMPL(a_ready_when_out_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  `ASSERT_IMPL(a_ready_when_out_taken, clk_i, rst_ni, m_axis_tready, s_axis_tready)
  // The padding above the code stays zero.
  `ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata >> (3 * BITS_PER_AXIS)) == '0)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind morton_code_from_box_centroid_unit mcb_checker #(
  .BITS_PER_AXIS(BITS_PER_AXIS),
  .OUT_TDATA_W  (OUT_TDATA_W)
) u_mcb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
